>>> src/sot_pkg.sv
// Shared types and constants for the sphere overlap table.
// Depends on nothing; sot_dist_unit, sphere_overlap_table and sot_checker import it.
package sot_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = SQ_W + 2;

    localparam int IN_W  = 72;
    localparam int OUT_W = 8;

    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_TRANSLATE,
        CMD_SET_CENTER,
        CMD_SET_RADIUS,
        CMD_REMOVE
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_OVERLAP,
        ST_BAD_RADIUS,
        ST_OCCUPIED,
        ST_EMPTY,
        ST_OVERFLOW
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]       r;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } sphere_t;

    typedef struct packed {
        logic             live;
        logic             check;
        logic [IDX_W-1:0] idx;
    } scan_tag_t;

    typedef struct packed {
        logic             live;
        logic             touch;
        logic [IDX_W-1:0] idx;
    } hit_t;

endpackage

>>> src/sot_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sot_dist_unit.sv
// Two-stage distance check: squares in the first stage, sum and compare in the second.
// Depends on sot_pkg.
module sot_dist_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  sot_pkg::scan_tag_t tag,
    input  sot_pkg::sphere_t   cand,
    input  sot_pkg::sphere_t   ent,
    output sot_pkg::hit_t      hit
);
    import sot_pkg::*;

    logic signed [COORD_W:0]  dx;
    logic signed [COORD_W:0]  dy;
    logic signed [COORD_W:0]  dz;
    logic [RADIUS_W:0]        rs;
    logic signed [2*COORD_W+1:0] px;
    logic signed [2*COORD_W+1:0] py;
    logic signed [2*COORD_W+1:0] pz;
    logic [2*RADIUS_W+1:0]    pr;

    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [SQ_W-1:0]  sqz_reg;
    logic [SQ_W-1:0]  sqr_reg;
    scan_tag_t        tag_reg;
    logic [SUM_W-1:0] d2;

    assign dx = {cand.x[COORD_W-1], cand.x} - {ent.x[COORD_W-1], ent.x};
    assign dy = {cand.y[COORD_W-1], cand.y} - {ent.y[COORD_W-1], ent.y};
    assign dz = {cand.z[COORD_W-1], cand.z} - {ent.z[COORD_W-1], ent.z};
    assign rs = {1'b0, cand.r} + {1'b0, ent.r};
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;
    assign pr = rs * rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
        sqr_reg <= pr[SQ_W-1:0];
    end

    assign d2 = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

    always_comb
    begin
        hit.live  = tag_reg.live;
        hit.idx   = tag_reg.idx;
        hit.touch = tag_reg.live && tag_reg.check && (d2 <= SUM_W'(sqr_reg));
    end

endmodule

>>> src/sphere_overlap_table.sv
// Top level of the sphere overlap table: command sequencer, valid bits and result register.
// Depends on sot_pkg, sot_ram and sot_dist_unit.
//
// One command item enters on the s_ channel and exactly one result item leaves on
// the m_ channel. s_tready is high only while the sequencer is idle, so one
// command is worked on at a time. The addressed entry is read at the accepting
// edge; the sequencer then checks radius, slot state and overflow. For a command
// that changes a sphere it streams every slot through the distance unit, one
// slot per cycle from the sphere RAM read port, drains its two stages and then
// loads the result register when it is free; remove, refused and unknown commands
// go to the result register without a scan.
// The first conflicting slot in slot order is reported and the table is then
// left unchanged. Results sit in an output register; a new command can be
// taken while a result waits, but the next result waits for m_tready.
// Reset empties the table (all valid bits clear) and drops any pending
// result; sphere contents are not cleared.
module sphere_overlap_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // cmd[2:0], slot[6:3], value_x[22:7], value_y[38:23], value_z[54:39],
    // radius[70:55], zero[71].
    input  logic [sot_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[2:0], conflict_valid[3], conflict_slot[7:4].
    output logic [sot_pkg::OUT_W-1:0] m_tdata
);
    import sot_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]          cmd_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                exists_reg;
    logic signed [15:0]  vx_reg, vy_reg, vz_reg, vr_reg;

    sphere_t             cand_reg, cand_next;
    status_t             status_reg, status_next;
    logic                commit_reg, commit_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    scan_tag_t           tag_reg, tag_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    found_idx_reg, found_idx_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;

    logic                out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                accept;
    logic                can_load;
    logic [IDX_W-1:0]    raddr;
    sphere_t             rdata;
    logic                we;
    hit_t                hit;
    logic                self_valid;
    logic signed [16:0]  tx, ty, tz;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign can_load = !out_vld_reg || m_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign self_valid = exists_reg && valid_reg[slot_reg];
    assign tx = {rdata.x[15], rdata.x} + {vx_reg[15], vx_reg};
    assign ty = {rdata.y[15], rdata.y} + {vy_reg[15], vy_reg};
    assign tz = {rdata.z[15], rdata.z} + {vz_reg[15], vz_reg};

    sot_ram #(
        .WIDTH($bits(sphere_t)),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(slot_reg),
        .wdata(cand_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    sot_dist_unit u_dist (
        .clk  (clk),
        .rst_n(rst_n),
        .tag  (tag_reg),
        .cand (cand_reg),
        .ent  (rdata),
        .hit  (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tag_reg     <= '0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
            commit_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tag_reg     <= tag_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
            out_vld_reg <= out_vld_next;
            commit_reg  <= commit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tdata[2:0];
            slot_reg   <= IDX_W'(s_tdata[6:3]);
            exists_reg <= 32'(s_tdata[6:3]) < SLOTS;
            vx_reg     <= s_tdata[22:7];
            vy_reg     <= s_tdata[38:23];
            vz_reg     <= s_tdata[54:39];
            vr_reg     <= s_tdata[70:55];
        end
        cand_reg      <= cand_next;
        status_reg    <= status_next;
        scan_reg      <= scan_next;
        found_idx_reg <= found_idx_next;
        out_data_reg  <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        status_next    = status_reg;
        commit_next    = commit_reg;
        scan_next      = scan_reg;
        tag_next       = '0;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        valid_next     = valid_reg;
        out_data_next  = out_data_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        raddr          = scan_reg;
        we             = 1'b0;

        if (hit.touch && !found_reg)
        begin
            found_next     = 1'b1;
            found_idx_next = hit.idx;
        end

        case (state_reg)
            S_IDLE:
            begin
                raddr = IDX_W'(s_tdata[6:3]);
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                status_next = ST_OK;
                commit_next = 1'b0;
                found_next  = 1'b0;
                scan_next   = '0;
                if ((cmd_reg == CMD_INSERT || cmd_reg == CMD_SET_RADIUS) && vr_reg[15])
                begin
                    status_next = ST_BAD_RADIUS;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    if (!exists_reg || valid_reg[slot_reg])
                    begin
                        status_next = ST_OCCUPIED;
                    end
                end
                else if (cmd_reg <= CMD_REMOVE && !self_valid)
                begin
                    status_next = ST_EMPTY;
                end

                if (status_next == ST_OK)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            cand_next.x = vx_reg;
                            cand_next.y = vy_reg;
                            cand_next.z = vz_reg;
                            cand_next.r = vr_reg[14:0];
                            commit_next = 1'b1;
                        end
                        CMD_TRANSLATE:
                        begin
                            cand_next.x = tx[15:0];
                            cand_next.y = ty[15:0];
                            cand_next.z = tz[15:0];
                            cand_next.r = rdata.r;
                            if (tx[16] != tx[15] || ty[16] != ty[15] || tz[16] != tz[15])
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                commit_next = 1'b1;
                            end
                        end
                        CMD_SET_CENTER:
                        begin
                            cand_next.x = vx_reg;
                            cand_next.y = vy_reg;
                            cand_next.z = vz_reg;
                            cand_next.r = rdata.r;
                            commit_next = 1'b1;
                        end
                        CMD_SET_RADIUS:
                        begin
                            cand_next   = rdata;
                            cand_next.r = vr_reg[14:0];
                            commit_next = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            valid_next[slot_reg] = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                state_next = commit_next ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                tag_next.live  = 1'b1;
                tag_next.check = valid_reg[scan_reg] && (scan_reg != slot_reg);
                tag_next.idx   = scan_reg;
                if (32'(scan_reg) == SLOTS - 1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!tag_reg.live && !hit.live)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    out_vld_next = 1'b1;
                    if (commit_reg && found_reg)
                    begin
                        out_data_next = {4'(found_idx_reg), 1'b1, ST_OVERLAP};
                    end
                    else
                    begin
                        out_data_next = {4'b0, 1'b0, status_reg};
                    end
                    if (commit_reg && !found_reg)
                    begin
                        we                   = 1'b1;
                        valid_next[slot_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/sot_checker.sv
// Port-level checks for the sphere overlap table, bound to the top level.
// Depends on sot_pkg and sphere_overlap_table.
module sot_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [sot_pkg::OUT_W-1:0] m_tdata
);
    import sot_pkg::*;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_OVERFLOW)
        else $error("Result status is out of range.");

    a_conflict_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == ST_OVERLAP))
                     && (m_tdata[3] || m_tdata[7:4] == 4'd0))
        else $error("Conflict flag and status disagree.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A second item was accepted while one was in work.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result item changed.");

endmodule

bind sphere_overlap_table sot_checker u_sot_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
